// File: rtl/core/rwmc_pkg.sv
// rwmc_pkg: widths, codes and helper functions of the random-walk maze carver
// used by random_walk_maze_carver_top; no dependencies

package rwmc_pkg;

   localparam int MAX_SIDE  = 64;
   localparam int COORD_W   = $clog2(MAX_SIDE);
   localparam int SIDE_W    = COORD_W + 1;
   localparam int IDX_W     = 2 * COORD_W;
   localparam int CNT_W     = IDX_W + 1;
   localparam int MAP_DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int EPOCH_W   = 4;
   localparam int DIR_W     = 2;

   localparam int SIDE_RESET = 16;

   // beat layouts
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 3;

   localparam logic KIND_BEGIN = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   // zero counts as one, anything beyond the largest side as the largest side
   function automatic logic [SIDE_W-1:0] side_in_use(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] r;
      if (v == '0) begin
         r = SIDE_W'(1);
      end else if (v > SIDE_W'(MAX_SIDE)) begin
         r = SIDE_W'(MAX_SIDE);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] clamp_below(input logic [COORD_W-1:0] v,
                                                      input logic [SIDE_W-1:0]  limit);
      logic [COORD_W-1:0] r;
      if (SIDE_W'(v) >= limit) begin
         r = COORD_W'(limit - SIDE_W'(1));
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] cell_index(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y,
                                                   input logic [SIDE_W-1:0]  w);
      logic [CNT_W-1:0] prod;
      prod = CNT_W'(y) * CNT_W'(w);
      return IDX_W'(prod + CNT_W'(x));
   endfunction

endpackage

// File: rtl/core/random_walk_maze_carver_top.sv
// random_walk_maze_carver_top: random-walk maze carver with the visited map in ram
// depends on rwmc_pkg and rwmc_ram
//
//   channel | dir | beat contents
//   req_    | in  | tuser kind, tdata direction / start_x / start_y
//   rsp_    | out | tuser carved / rejected / done_res, tdata from / to / dir / remaining
//   csr_    | in  | write enable, register index, data
//
// a step has two states: accept (visited-map read issued) and check/update
// (map write-back, result loaded); the single map ram's registered read sets this
// a begin has the accept and begin states, plus a clearing pass of the map (4096 writes
// and a re-entry to the begin state) on the first begin after reset and on every
// fifteenth begin after that (map entries hold a run tag), during which req_tready
// stays low; synchronous active-high reset; a full result register stalls begin and update

module random_walk_maze_carver_top (
   input  logic                            clock,
   input  logic                            reset,
   // slave side
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_tuser,  // kind
   input  logic [rwmc_pkg::REQ_DATA_W-1:0] req_tdata,  // direction, start_x, start_y, pad
   // master side
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rwmc_pkg::RSP_USER_W-1:0] rsp_tuser,  // carved, rejected, done_res
   output logic [rwmc_pkg::RSP_DATA_W-1:0] rsp_tdata,  // from_index, to_index,
                                                       // step_direction, remaining, pad
   // configuration
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [rwmc_pkg::SIDE_W-1:0]     csr_wdata
);

   localparam int CW = rwmc_pkg::COORD_W;
   localparam int SW = rwmc_pkg::SIDE_W;
   localparam int IW = rwmc_pkg::IDX_W;
   localparam int NW = rwmc_pkg::CNT_W;
   localparam int EW = rwmc_pkg::EPOCH_W;
   localparam int DW = rwmc_pkg::DIR_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BEGIN,
      ST_SWEEP,
      ST_CHECK
   } state_type;

   state_type        state_ff, state_in;
   logic [EW-1:0]    epoch_ff, epoch_in;
   logic [IW-1:0]    sweep_ff, sweep_in;
   logic [SW-1:0]    width_ff, width_in;
   logic [SW-1:0]    height_ff, height_in;
   logic [CW-1:0]    walker_x_ff, walker_x_in;
   logic [CW-1:0]    walker_y_ff, walker_y_in;
   logic [NW-1:0]    cells_left_ff, cells_left_in;

   // item held between accept and update
   logic [DW-1:0]    item_dir_ff, item_dir_in;
   logic [IW-1:0]    item_here_ff, item_here_in;
   logic [IW-1:0]    item_there_ff, item_there_in;
   logic             item_reject_ff, item_reject_in;
   logic [CW-1:0]    item_nx_ff, item_nx_in;
   logic [CW-1:0]    item_ny_ff, item_ny_in;
   logic [NW-1:0]    item_cells_ff, item_cells_in;

   // result register
   logic             out_valid_ff, out_valid_in;
   logic [IW-1:0]    out_from_ff, out_from_in;
   logic [IW-1:0]    out_to_ff, out_to_in;
   logic [DW-1:0]    out_dir_ff, out_dir_in;
   logic             out_carved_ff, out_carved_in;
   logic             out_rejected_ff, out_rejected_in;
   logic [NW-1:0]    out_remaining_ff, out_remaining_in;

   logic             in_kind;
   logic [DW-1:0]    in_dir;
   logic [CW-1:0]    in_sx, in_sy;
   logic [SW-1:0]    w, h;
   logic [CW-1:0]    wx, wy, sx, sy, nx, ny;
   logic             off;
   logic [IW-1:0]    here_idx, there_idx;
   logic [NW-1:0]    area;
   logic             accept, out_free, carve_now;

   logic             mem_we;
   logic [IW-1:0]    mem_waddr, mem_raddr;
   logic [EW-1:0]    mem_wdata, mem_rdata;

   assign in_kind = req_tuser;
   assign in_dir  = req_tdata[DW-1:0];
   assign in_sx   = req_tdata[DW +: CW];
   assign in_sy   = req_tdata[DW+CW +: CW];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   assign w  = rwmc_pkg::side_in_use(width_ff);
   assign h  = rwmc_pkg::side_in_use(height_ff);
   assign wx = rwmc_pkg::clamp_below(walker_x_ff, w);
   assign wy = rwmc_pkg::clamp_below(walker_y_ff, h);
   assign sx = rwmc_pkg::clamp_below(in_sx, w);
   assign sy = rwmc_pkg::clamp_below(in_sy, h);

   always_comb begin
      nx  = wx;
      ny  = wy;
      off = 1'b0;
      unique case (in_dir)
         rwmc_pkg::DIR_UP: begin
            if (wy == '0) off = 1'b1; else ny = wy - CW'(1);
         end
         rwmc_pkg::DIR_RIGHT: begin
            if (SW'(wx) + SW'(1) >= w) off = 1'b1; else nx = wx + CW'(1);
         end
         rwmc_pkg::DIR_DOWN: begin
            if (SW'(wy) + SW'(1) >= h) off = 1'b1; else ny = wy + CW'(1);
         end
         rwmc_pkg::DIR_LEFT: begin
            if (wx == '0) off = 1'b1; else nx = wx - CW'(1);
         end
         default: off = 1'b1;
      endcase
   end

   assign here_idx  = (in_kind == rwmc_pkg::KIND_BEGIN) ? rwmc_pkg::cell_index(sx, sy, w)
                                                       : rwmc_pkg::cell_index(wx, wy, w);
   assign there_idx = rwmc_pkg::cell_index(nx, ny, w);
   assign area      = NW'(w) * NW'(h);

   // map entry belongs to the current run when it carries the current tag
   assign carve_now = (state_ff == ST_CHECK) && out_free && !item_reject_ff
                      && (mem_rdata != epoch_ff);

   // keep the read address steady while the update waits on the result register
   assign mem_raddr = (state_ff == ST_IDLE) ? there_idx : item_there_ff;

   always_comb begin
      state_in         = state_ff;
      epoch_in         = epoch_ff;
      sweep_in         = sweep_ff;
      width_in         = width_ff;
      height_in        = height_ff;
      walker_x_in      = walker_x_ff;
      walker_y_in      = walker_y_ff;
      cells_left_in    = cells_left_ff;
      item_dir_in      = item_dir_ff;
      item_here_in     = item_here_ff;
      item_there_in    = item_there_ff;
      item_reject_in   = item_reject_ff;
      item_nx_in       = item_nx_ff;
      item_ny_in       = item_ny_ff;
      item_cells_in    = item_cells_ff;
      out_valid_in     = out_valid_ff && !rsp_tready;
      out_from_in      = out_from_ff;
      out_to_in        = out_to_ff;
      out_dir_in       = out_dir_ff;
      out_carved_in    = out_carved_ff;
      out_rejected_in  = out_rejected_ff;
      out_remaining_in = out_remaining_ff;
      mem_we           = 1'b0;
      mem_waddr        = item_there_ff;
      mem_wdata        = epoch_ff;

      if (csr_we) begin
         unique case (csr_index)
            rwmc_pkg::CSR_GRID_WIDTH:  width_in  = csr_wdata;
            rwmc_pkg::CSR_GRID_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_dir_in  = in_dir;
               item_here_in = here_idx;
               if (in_kind == rwmc_pkg::KIND_BEGIN) begin
                  item_there_in  = here_idx;
                  item_reject_in = 1'b0;
                  item_nx_in     = sx;
                  item_ny_in     = sy;
                  item_cells_in  = area - NW'(1);
                  state_in       = ST_BEGIN;
               end else begin
                  item_reject_in = off || (cells_left_ff == '0);
                  item_there_in  = (off || (cells_left_ff == '0)) ? here_idx : there_idx;
                  item_nx_in     = (off || (cells_left_ff == '0)) ? wx : nx;
                  item_ny_in     = (off || (cells_left_ff == '0)) ? wy : ny;
                  state_in       = ST_CHECK;
               end
            end
         end
         ST_BEGIN: begin
            if (epoch_ff == '1) begin
               sweep_in = '0;
               state_in = ST_SWEEP;
            end else if (out_free) begin
               epoch_in         = epoch_ff + EW'(1);
               mem_we           = 1'b1;
               mem_waddr        = item_here_ff;
               mem_wdata        = epoch_ff + EW'(1);
               walker_x_in      = item_nx_ff;
               walker_y_in      = item_ny_ff;
               cells_left_in    = item_cells_ff;
               out_valid_in     = 1'b1;
               out_from_in      = item_here_ff;
               out_to_in        = item_here_ff;
               out_dir_in       = rwmc_pkg::DIR_UP;
               out_carved_in    = 1'b0;
               out_rejected_in  = 1'b0;
               out_remaining_in = item_cells_ff;
               state_in         = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '0;
            sweep_in  = sweep_ff + IW'(1);
            if (sweep_ff == IW'(rwmc_pkg::MAP_DEPTH - 1)) begin
               epoch_in = '0;
               state_in = ST_BEGIN;
            end
         end
         ST_CHECK: begin
            if (out_free) begin
               if (carve_now) begin
                  mem_we        = 1'b1;
                  cells_left_in = cells_left_ff - NW'(1);
               end
               walker_x_in      = item_nx_ff;
               walker_y_in      = item_ny_ff;
               out_valid_in     = 1'b1;
               out_from_in      = item_here_ff;
               out_to_in        = item_there_ff;
               out_dir_in       = item_dir_ff;
               out_carved_in    = carve_now;
               out_rejected_in  = item_reject_ff;
               out_remaining_in = carve_now ? cells_left_ff - NW'(1) : cells_left_ff;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         epoch_ff      <= '1;  // forces a clearing pass on the first begin
         width_ff      <= SW'(rwmc_pkg::SIDE_RESET);
         height_ff     <= SW'(rwmc_pkg::SIDE_RESET);
         walker_x_ff   <= '0;
         walker_y_ff   <= '0;
         cells_left_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         epoch_ff      <= epoch_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         walker_x_ff   <= walker_x_in;
         walker_y_ff   <= walker_y_in;
         cells_left_ff <= cells_left_in;
         out_valid_ff  <= out_valid_in;
      end
      sweep_ff         <= sweep_in;
      item_dir_ff      <= item_dir_in;
      item_here_ff     <= item_here_in;
      item_there_ff    <= item_there_in;
      item_reject_ff   <= item_reject_in;
      item_nx_ff       <= item_nx_in;
      item_ny_ff       <= item_ny_in;
      item_cells_ff    <= item_cells_in;
      out_from_ff      <= out_from_in;
      out_to_ff        <= out_to_in;
      out_dir_ff       <= out_dir_in;
      out_carved_ff    <= out_carved_in;
      out_rejected_ff  <= out_rejected_in;
      out_remaining_ff <= out_remaining_in;
   end

   rwmc_ram #(
      .WIDTH (EW),
      .DEPTH (rwmc_pkg::MAP_DEPTH)
   ) u_visited_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {(out_remaining_ff == '0), out_rejected_ff, out_carved_ff};
   assign rsp_tdata  = {(rwmc_pkg::RSP_DATA_W - 2*IW - DW - NW)'(0),
                        out_remaining_ff, out_dir_ff, out_to_ff, out_from_ff};

`ifndef NO_ASSERTIONS
   // no item is taken while the map is being cleared
   a_sweep_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> !req_tready)
      else $error("input taken during map clearing pass");

   // a carved cell lowers the unvisited count by exactly one
   a_carve_counts_down: assert property (@(posedge clock) disable iff (reset)
      carve_now |=> (cells_left_ff == $past(cells_left_ff) - NW'(1)))
      else $error("carve did not decrement the unvisited count");

   // the map is written only while an item or the clearing pass is in progress
   a_map_write_busy: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff != ST_IDLE))
      else $error("visited map written while idle");

   // a waiting result is never overwritten
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_from_ff)
                                         && $stable(out_remaining_ff)))
      else $error("pending result overwritten");
`endif

endmodule

// File: rtl/core/rwmc_ram.sv
// rwmc_ram: generic single-clock ram, one write port and one registered read port
// no dependencies

module rwmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
